FILE: design/deq_pkg.sv
// ============================================================================
// Double-ended queue package
// Command and status codes and the controller-to-datapath command types.
// ============================================================================
package deq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int CMD_W    = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      RD_HEAD = 2'd0,
      RD_TAIL = 2'd1,
      RD_LIST = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic                wr_front;
      logic                wr_rear;
      logic                pop_front;
      logic                pop_rear;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                idx_clr;
      logic                idx_inc;
      logic                out_load;
      logic                out_from_mem;
      logic [STATUS_W-1:0] out_status;
      logic                out_last;
   } deq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
      logic out_free;
   } deq_stat_type;

endpackage

FILE: design/deq_if.sv
// ============================================================================
// Double-ended queue channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ============================================================================
interface deq_req_if;
   import deq_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [WORD_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   word;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output word, output status, output last, input ready);
   modport sink   (input valid, input word, input status, input last, output ready);
endinterface

FILE: design/deq_ctrl.sv
// ============================================================================
// Double-ended queue controller
// Decodes command transactions and sequences pops and list readouts.
// ============================================================================
module deq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [deq_pkg::CMD_W-1:0] req_command,
   input  deq_pkg::deq_stat_type     stat,
   output deq_pkg::deq_cmd_type      cmd
);
   import deq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_LIST = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_HEAD;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               case (req_command) inside
                  CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                     cmd.out_load   = 1'b1;
                     cmd.out_last   = 1'b1;
                     cmd.out_status = stat.full ? ST_FULL : ST_OK;
                     cmd.wr_front   = !stat.full && (req_command == CMD_PUSH_FRONT);
                     cmd.wr_rear    = !stat.full && (req_command == CMD_PUSH_REAR);
                  end
                  CMD_POP_FRONT, CMD_POP_REAR: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.rd_en = 1'b1;
                        if (req_command == CMD_POP_FRONT) begin
                           cmd.pop_front = 1'b1;
                           cmd.rd_sel    = RD_HEAD;
                        end else begin
                           cmd.pop_rear = 1'b1;
                           cmd.rd_sel   = RD_TAIL;
                        end
                        state_in = S_POP;
                     end
                  end
                  CMD_LIST: begin
                     if (stat.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_HEAD;
                        cmd.idx_clr = 1'b1;
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_status   = ST_OK;
               cmd.out_last     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_LIST: begin
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_status   = ST_OK;
               cmd.out_last     = stat.list_last;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = RD_LIST;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/deq_dpath.sv
// ============================================================================
// Double-ended queue datapath
// Ring buffer storage, head and count registers, and the result register.
// ============================================================================
module deq_dpath #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  deq_pkg::deq_cmd_type         cmd,
   output deq_pkg::deq_stat_type        stat,
   input  logic [deq_pkg::WORD_W-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [deq_pkg::WORD_W-1:0]   rsp_word,
   output logic [deq_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);
   import deq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[IW-1:0];
   endfunction

   logic [WORD_W-1:0]   entry_mem_ff [DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic [IW-1:0]       head_ff;
   logic [IW-1:0]       head_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [IW-1:0]       idx_ff;
   logic [IW-1:0]       idx_in;
   logic [IW-1:0]       head_dec;
   logic [IW-1:0]       tail_addr;
   logic [IW-1:0]       rear_addr;
   logic [IW-1:0]       wr_addr;
   logic [IW-1:0]       rd_addr;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   assign head_dec  = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - IW'(1);
   assign tail_addr = ring_add(head_ff, count_ff[IW-1:0]);
   assign rear_addr = ring_add(head_ff, IW'(count_ff - CW'(1)));
   assign wr_addr   = cmd.wr_front ? head_dec : tail_addr;

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_addr = head_ff;
         RD_TAIL: rd_addr = rear_addr;
         RD_LIST: rd_addr = ring_add(head_ff, idx_ff + IW'(1));
         default: rd_addr = head_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_front || cmd.wr_rear) begin
         entry_mem_ff[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.wr_front) begin
         head_in  = head_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.wr_rear) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_front) begin
         head_in  = ring_add(head_ff, IW'(1));
         count_in = count_ff - CW'(1);
      end else if (cmd.pop_rear) begin
         count_in = count_ff - CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_word_ff   <= cmd.out_from_mem ? rd_data_ff : '0;
         rsp_status_ff <= cmd.out_status;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.list_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: design/double_ended_queue_core.sv
// A push or refused command has its result registered in the cycle after acceptance;
// a pop loads the entry into the registered memory read, then into the result register.
// Throughput: one push per cycle while the result channel does not stall; a pop is done
// before the next command is taken; a list of N entries makes one memory read per entry.
// Reset: synchronous; the queue is emptied with head and count at zero, and the
// storage contents are left as they are.
// ============================================================================
// Double-ended queue core
// Bounded double-ended queue of 32-bit words with push, pop and list commands.
// ============================================================================
module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   deq_cmd_type  cmd;
   deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .stat        (stat),
      .cmd         (cmd)
   );

   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_chan.value),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_word   (rsp_chan.word),
      .rsp_status (rsp_chan.status),
      .rsp_last   (rsp_chan.last)
   );

endmodule

FILE: sim/double_ended_queue_core_test.sv
// ============================================================================
// Double-ended queue core testbench
// Drives push, pop, list and unused command transactions into the core with
// random gaps and result stalls. A shadow ring buffer predicts every result,
// and each result transaction is compared field by field against the oldest
// outstanding prediction.
// ============================================================================
module double_ended_queue_core_test;
   import deq_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 220;

   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] value;
      bit                hold_until_drained;
   } deque_cmd_type;

   typedef struct {
      logic [WORD_W-1:0]   word;
      logic [STATUS_W-1:0] status;
      logic                last;
   } deque_result_type;

   logic clock;
   logic reset;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_core #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   deque_cmd_type    cmd_backlog[$];
   deque_result_type due_results[$];

   logic [WORD_W-1:0] shadow_store[DEPTH];
   int shadow_head;
   int shadow_count;

   int fail_count;
   int total_cmds;
   int accepted_total;
   int result_total;
   int cycle_count;
   int req_gap;
   int rsp_stall;
   bit quiet_phase;

   int pushes_done;
   int pushes_refused;
   int pops_done;
   int pops_refused;
   int lists_done;
   int list_words;
   int cmds_ignored;
   int peak_count;

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                            input bit hold);
      deque_cmd_type item;
      item.command = cmd;
      item.value = val;
      item.hold_until_drained = hold;
      cmd_backlog.push_back(item);
      total_cmds++;
   endtask

   function automatic deque_result_type make_result(input logic [WORD_W-1:0] word,
                                                    input logic [STATUS_W-1:0] status,
                                                    input logic last);
      deque_result_type r;
      r.word = word;
      r.status = status;
      r.last = last;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(5, 30);
      end
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mode 0 mostly pushes, mode 1 mostly pops, mode 2 is an even mix.
   function automatic logic [CMD_W-1:0] pick_command(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (r < 40) return CMD_PUSH_FRONT;
            else if (r < 82) return CMD_PUSH_REAR;
            else if (r < 88) return CMD_POP_FRONT;
            else if (r < 94) return CMD_POP_REAR;
            else if (r < 98) return CMD_LIST;
         end
         1: begin
            if (r < 6) return CMD_PUSH_FRONT;
            else if (r < 12) return CMD_PUSH_REAR;
            else if (r < 53) return CMD_POP_FRONT;
            else if (r < 94) return CMD_POP_REAR;
            else if (r < 98) return CMD_LIST;
         end
         default: begin
            if (r < 22) return CMD_PUSH_FRONT;
            else if (r < 44) return CMD_PUSH_REAR;
            else if (r < 66) return CMD_POP_FRONT;
            else if (r < 88) return CMD_POP_REAR;
            else if (r < 96) return CMD_LIST;
         end
      endcase
      case ($urandom_range(0, 2))
         0: return CMD_SPARE_5;
         1: return CMD_SPARE_6;
         default: return CMD_SPARE_7;
      endcase
   endfunction

   task automatic apply_to_shadow(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val);
      int pos;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (shadow_count >= DEPTH) begin
               due_results.push_back(make_result('0, ST_FULL, 1'b1));
               pushes_refused++;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  pos = shadow_head;
               end else begin
                  pos = (shadow_head + shadow_count) % DEPTH;
               end
               shadow_store[pos] = val;
               shadow_count++;
               if (shadow_count > peak_count) begin
                  peak_count = shadow_count;
               end
               due_results.push_back(make_result('0, ST_OK, 1'b1));
               pushes_done++;
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (shadow_count == 0) begin
               due_results.push_back(make_result('0, ST_EMPTY, 1'b1));
               pops_refused++;
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  pos = shadow_head;
                  shadow_head = (shadow_head + 1) % DEPTH;
               end else begin
                  pos = (shadow_head + shadow_count - 1) % DEPTH;
               end
               shadow_count--;
               due_results.push_back(make_result(shadow_store[pos], ST_OK, 1'b1));
               pops_done++;
            end
         end
         CMD_LIST: begin
            lists_done++;
            if (shadow_count == 0) begin
               due_results.push_back(make_result('0, ST_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  pos = (shadow_head + i) % DEPTH;
                  due_results.push_back(make_result(shadow_store[pos], ST_OK,
                                                    i == shadow_count - 1));
                  list_words++;
               end
            end
         end
         default: begin
            cmds_ignored++;
         end
      endcase
   endtask

   always @(posedge clock) begin : drive_req
      deque_cmd_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_to_shadow(req_bus.command, req_bus.value);
            accepted_total++;
            if ($urandom_range(0, 29) == 0) begin
               quiet_phase = !quiet_phase;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].hold_until_drained && due_results.size() != 0)) begin
               item = cmd_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= item.command;
               req_bus.value <= item.value;
               req_gap <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      deque_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_total++;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word=%h status=%0d last=%0b",
                                         rsp_bus.word, rsp_bus.status, rsp_bus.last));
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.word !== want.word) begin
                  report_mismatch($sformatf("result %0d word %h, expected %h",
                                            result_total, rsp_bus.word, want.word));
               end
               if (rsp_bus.status !== want.status) begin
                  report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                            result_total, rsp_bus.status, want.status));
               end
               if (rsp_bus.last !== want.last) begin
                  report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                            result_total, rsp_bus.last, want.last));
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) begin
               rsp_stall <= pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : run_test
      int mode;
      int burst;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      shadow_head = 0;
      shadow_count = 0;
      quiet_phase = 1'b0;

      // Empty queue: refused pops, empty list and the unused codes.
      queue_cmd(CMD_LIST, 32'h0, 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_POP_REAR, 32'h8000_0000, 1'b0);
      queue_cmd(CMD_SPARE_5, 32'h1234_5678, 1'b0);
      queue_cmd(CMD_SPARE_6, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_SPARE_7, 32'h0, 1'b0);
      queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
      queue_cmd(CMD_PUSH_REAR, 32'h8000_0000, 1'b0);
      queue_cmd(CMD_PUSH_FRONT, 32'h0000_0000, 1'b0);
      queue_cmd(CMD_PUSH_REAR, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_LIST, 32'h0, 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'h0, 1'b0);
      queue_cmd(CMD_POP_REAR, 32'h0, 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'h0, 1'b0);
      queue_cmd(CMD_LIST, 32'h0, 1'b0);
      // The single remaining entry must still be reported by the pop.
      queue_cmd(CMD_POP_REAR, 32'h0, 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'h0, 1'b0);
      queue_cmd(CMD_LIST, 32'h0, 1'b1);
      queue_cmd(CMD_PUSH_REAR, 32'h5A5A_A5A5, 1'b0);
      queue_cmd(CMD_POP_FRONT, 32'h0, 1'b0);

      while (total_cmds < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         burst = (mode == 0) ? $urandom_range(20, 36) : $urandom_range(8, 30);
         for (int i = 0; i < burst; i++) begin
            queue_cmd(pick_command(mode), pick_word(),
                      i == 0 && $urandom_range(0, 3) == 0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_total < total_cmds) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d commands: %0d pushes, %0d refused full, %0d pops, %0d refused empty",
               accepted_total, pushes_done, pushes_refused, pops_done, pops_refused);
      $display("%0d lists returned %0d entries, %0d unused codes ignored, peak occupancy %0d",
               lists_done, list_words, cmds_ignored, peak_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
design/deq_pkg.sv
design/deq_if.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue_core.sv
sim/double_ended_queue_core_test.sv
